// ===== hdl/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg: shared widths and types for the triangle face normal pipeline
// Widths follow from the coordinate width and the normal fraction bits.
// ----------------------------------------------------------------------------
package tfn_pkg;

   localparam int CW   = 16;           // coordinate width, Q8.8
   localparam int NF   = 14;           // fraction bits of the normal
   localparam int DW   = CW + 1;       // edge vector component
   localparam int PW   = 2 * DW;       // cross product partial product
   localparam int NW   = PW + 1;       // cross product component, signed
   localparam int MW   = NW;           // component magnitude
   localparam int SPL  = (MW + 1) / 2; // low half of a magnitude for squaring
   localparam int HW   = MW - SPL;     // high half
   localparam int SW   = 2 * MW + 2;   // sum of squares
   localparam int RW   = SW / 2;       // square root
   localparam int REMW = RW + 3;       // square root partial remainder
   localparam int QW   = NF + 1;       // quotient magnitude
   localparam int OW   = NF + 2;       // normal component, signed

   // magnitudes and signs of the cross product riding along the pipeline
   typedef struct packed {
      logic [2:0][MW-1:0] mag;
      logic [2:0]         neg;
   } tfn_tag_type;

endpackage

// ===== hdl/triangle_face_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal: fixed point unit face normal of a triangle
// Pipeline stages: edge vectors, cross product, squares and sum, one root
// bit per sqrt stage, one quotient bit per divide stage, output register.
// Throughput one triangle per cycle; a stalled output holds the whole
// pipeline. Synchronous reset clears the valid bits only; no clearing pass.
// ----------------------------------------------------------------------------
module triangle_face_normal (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
   input  logic [9*tfn_pkg::CW-1:0]   req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // norm_x, norm_y, norm_z from bit 0 up
   output logic [3*tfn_pkg::OW-1:0]   rsp_tdata,
   // degenerate
   output logic                       rsp_tuser
);
   import tfn_pkg::*;

   logic pipe_en;

   // stage 1: edge vectors
   logic                 v1_ff;
   logic signed [DW-1:0] p_ff [3];
   logic signed [DW-1:0] q_ff [3];
   logic signed [DW-1:0] p_in [3];
   logic signed [DW-1:0] q_in [3];

   // stage 2: cross product partial products
   logic                 v2_ff;
   logic signed [PW-1:0] prod_ff [6];
   logic signed [PW-1:0] prod_in [6];
   logic signed [PW-1:0] pe [3];
   logic signed [PW-1:0] qe [3];

   // stage 3: components as sign and magnitude
   logic            v3_ff;
   tfn_tag_type     tag3_ff, tag3_in;

   // stage 4: square partial products
   logic                      v4_ff;
   tfn_tag_type               tag4_ff;
   logic [2:0][2*HW-1:0]      hh_ff, hh_in;
   logic [2:0][HW+SPL-1:0]    hl_ff, hl_in;
   logic [2:0][2*SPL-1:0]     ll_ff, ll_in;

   // stage 5: squares
   logic                 v5_ff;
   tfn_tag_type          tag5_ff;
   logic [2:0][SW-1:0]   sq_ff, sq_in;

   // stage 6: sum of squares
   logic                 v6_ff;
   tfn_tag_type          tag6_ff;
   logic [SW-1:0]        sum_ff, sum_in;

   logic                 sq_v;
   logic [RW-1:0]        sq_root;
   tfn_tag_type          sq_tag;

   logic                 dv_v;
   logic [2:0][QW-1:0]   dv_quot;
   logic [2:0]           dv_neg;
   logic                 dv_degen;

   logic                 out_v_ff;
   logic [2:0][OW-1:0]   norm_ff, norm_in;
   logic                 degen_ff;

   assign pipe_en    = !out_v_ff || rsp_tready;
   assign req_tready = pipe_en && !reset;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in[i] = DW'($signed(req_tdata[i*CW +: CW]))
                 - DW'($signed(req_tdata[(i+3)*CW +: CW]));
         q_in[i] = DW'($signed(req_tdata[i*CW +: CW]))
                 - DW'($signed(req_tdata[(i+6)*CW +: CW]));
         pe[i]   = PW'(p_ff[i]);
         qe[i]   = PW'(q_ff[i]);
      end
      prod_in[0] = pe[1] * qe[2];
      prod_in[1] = pe[2] * qe[1];
      prod_in[2] = pe[2] * qe[0];
      prod_in[3] = pe[0] * qe[2];
      prod_in[4] = pe[0] * qe[1];
      prod_in[5] = pe[1] * qe[0];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [NW-1:0] n;
         n = NW'(prod_ff[2*i]) - NW'(prod_ff[2*i+1]);
         tag3_in.neg[i] = n[NW-1];
         tag3_in.mag[i] = n[NW-1] ? MW'(-n) : MW'(n);
      end
   end

   // square split into high and low halves to keep multipliers narrow
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [HW-1:0]  mh;
         logic [SPL-1:0] ml;
         mh       = tag3_ff.mag[i][MW-1:SPL];
         ml       = tag3_ff.mag[i][SPL-1:0];
         hh_in[i] = (2*HW)'(mh) * (2*HW)'(mh);
         hl_in[i] = (HW+SPL)'(mh) * (HW+SPL)'(ml);
         ll_in[i] = (2*SPL)'(ml) * (2*SPL)'(ml);
         sq_in[i] = (SW'(hh_ff[i]) << (2*SPL)) + (SW'(hl_ff[i]) << (SPL+1))
                  + SW'(ll_ff[i]);
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
      if (pipe_en) begin
         p_ff    <= p_in;
         q_ff    <= q_in;
         prod_ff <= prod_in;
         tag3_ff <= tag3_in;
         tag4_ff <= tag3_ff;
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         ll_ff   <= ll_in;
         tag5_ff <= tag4_ff;
         sq_ff   <= sq_in;
         tag6_ff <= tag5_ff;
         sum_ff  <= sum_in;
      end
   end

   tfn_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (v6_ff),
      .in_rad    (sum_ff),
      .in_tag    (tag6_ff),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   tfn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (sq_v),
      .in_len    (sq_root),
      .in_tag    (sq_tag),
      .out_valid (dv_v),
      .out_quot  (dv_quot),
      .out_neg   (dv_neg),
      .out_degen (dv_degen)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_degen) begin
            norm_in[i] = '0;
         end else if (dv_neg[i]) begin
            norm_in[i] = -OW'(dv_quot[i]);
         end else begin
            norm_in[i] = OW'(dv_quot[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (pipe_en) begin
         out_v_ff <= dv_v;
      end
      if (pipe_en) begin
         norm_ff  <= norm_in;
         degen_ff <= dv_degen;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = norm_ff;
   assign rsp_tuser  = degen_ff;

   // a degenerate triangle reports an all-zero normal
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate result with nonzero normal");

   // each component of a unit normal stays within one
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(norm_ff[0]) <= $signed(OW'(1 << NF)))
                  && ($signed(norm_ff[0]) >= -$signed(OW'(1 << NF)))
                  && ($signed(norm_ff[1]) <= $signed(OW'(1 << NF)))
                  && ($signed(norm_ff[1]) >= -$signed(OW'(1 << NF)))
                  && ($signed(norm_ff[2]) <= $signed(OW'(1 << NF)))
                  && ($signed(norm_ff[2]) >= -$signed(OW'(1 << NF))))
      else $error("normal component out of range");

   // a stall freezes the front of the pipeline
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(v6_ff) && $stable(sum_ff) && $stable(v1_ff))
      else $error("pipeline moved during stall");

endmodule

// ===== hdl/tfn_isqrt.sv =====
// ----------------------------------------------------------------------------
// tfn_isqrt: pipelined floor square root
// One result bit per stage, restoring digit recurrence, tag carried along.
// ----------------------------------------------------------------------------
module tfn_isqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [tfn_pkg::SW-1:0]  in_rad,
   input  tfn_pkg::tfn_tag_type    in_tag,
   output logic                    out_valid,
   output logic [tfn_pkg::RW-1:0]  out_root,
   output tfn_pkg::tfn_tag_type    out_tag
);
   import tfn_pkg::*;

   logic              v_ff    [0:RW-1];
   logic [SW-1:0]     rad_ff  [0:RW-1];
   logic [REMW-1:0]   rem_ff  [0:RW-1];
   logic [RW-1:0]     root_ff [0:RW-1];
   tfn_tag_type       tag_ff  [0:RW-1];

   for (genvar g = 0; g < RW; g++) begin : g_stage
      logic            src_v;
      logic [SW-1:0]   src_rad;
      logic [REMW-1:0] src_rem;
      logic [RW-1:0]   src_root;
      tfn_tag_type     src_tag;
      logic [REMW-1:0] cur;
      logic [REMW-1:0] trial;
      logic            ge;
      logic [REMW-1:0] rem_in;
      logic [RW-1:0]   root_in;

      if (g == 0) begin : g_first
         assign src_v    = in_valid;
         assign src_rad  = in_rad;
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_tag  = in_tag;
      end else begin : g_next
         assign src_v    = v_ff[g-1];
         assign src_rad  = rad_ff[g-1];
         assign src_rem  = rem_ff[g-1];
         assign src_root = root_ff[g-1];
         assign src_tag  = tag_ff[g-1];
      end

      always_comb begin
         cur     = {src_rem[REMW-3:0], src_rad[SW-1 -: 2]};
         trial   = {{(REMW-RW-2){1'b0}}, src_root, 2'b01};
         ge      = (cur >= trial);
         rem_in  = ge ? (cur - trial) : cur;
         root_in = {src_root[RW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= src_v;
         end
         if (en) begin
            rad_ff[g]  <= {src_rad[SW-3:0], 2'b00};
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            tag_ff[g]  <= src_tag;
         end
      end
   end

   assign out_valid = v_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_tag   = tag_ff[RW-1];

endmodule

// ===== hdl/tfn_div.sv =====
// ----------------------------------------------------------------------------
// tfn_div: pipelined scaled divide, three lanes sharing one divisor
// Gives floor(mag * 2^NF / len) one quotient bit per stage.
// ----------------------------------------------------------------------------
module tfn_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [tfn_pkg::RW-1:0]       in_len,
   input  tfn_pkg::tfn_tag_type         in_tag,
   output logic                         out_valid,
   output logic [2:0][tfn_pkg::QW-1:0]  out_quot,
   output logic [2:0]                   out_neg,
   output logic                         out_degen
);
   import tfn_pkg::*;

   logic                 v_ff   [0:QW-1];
   logic [RW-1:0]        len_ff [0:QW-1];
   logic [2:0][RW-1:0]   rem_ff [0:QW-1];
   logic [2:0][QW-1:0]   q_ff   [0:QW-1];
   logic [2:0]           neg_ff [0:QW-1];
   logic                 dg_ff  [0:QW-1];

   for (genvar g = 0; g < QW; g++) begin : g_stage
      logic               src_v;
      logic [RW-1:0]      src_len;
      logic [2:0][RW:0]   src_sh;
      logic [2:0][QW-1:0] src_q;
      logic [2:0]         src_neg;
      logic               src_dg;
      logic [2:0][RW-1:0] rem_in;
      logic [2:0][QW-1:0] q_in;

      if (g == 0) begin : g_first
         assign src_v   = in_valid;
         assign src_len = in_len;
         assign src_q   = '0;
         assign src_neg = in_tag.neg;
         assign src_dg  = (in_len == '0);
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign src_sh[l] = (RW+1)'(in_tag.mag[l]);
         end
      end else begin : g_next
         assign src_v   = v_ff[g-1];
         assign src_len = len_ff[g-1];
         assign src_q   = q_ff[g-1];
         assign src_neg = neg_ff[g-1];
         assign src_dg  = dg_ff[g-1];
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign src_sh[l] = {rem_ff[g-1][l], 1'b0};
         end
      end

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            logic         ge;
            logic [RW:0]  diff;
            ge        = (src_sh[l] >= {1'b0, src_len});
            diff      = src_sh[l] - {1'b0, src_len};
            rem_in[l] = ge ? diff[RW-1:0] : src_sh[l][RW-1:0];
            q_in[l]   = {src_q[l][QW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= src_v;
         end
         if (en) begin
            len_ff[g] <= src_len;
            rem_ff[g] <= rem_in;
            q_ff[g]   <= q_in;
            neg_ff[g] <= src_neg;
            dg_ff[g]  <= src_dg;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_quot  = q_ff[QW-1];
   assign out_neg   = neg_ff[QW-1];
   assign out_degen = dg_ff[QW-1];

endmodule
